/* rtl/iirq15_pkg.sv */
// Shared types and constants for the Q15 direct form I IIR filter.
`default_nettype none

package iirq15_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int PROD_W    = 32;
  localparam int ACC_W     = 48;
  localparam int Q_SHIFT   = 15;
  localparam int FWD_CNT_W = 6;
  localparam int FBK_CNT_W = 5;
  localparam int CFG_W     = 6;
  localparam int TAP_IDX_W = 5;

  typedef enum logic [1:0] {
    ACT_FILTER   = 2'd0,
    ACT_LOAD_FWD = 2'd1,
    ACT_LOAD_FBK = 2'd2,
    ACT_CLEAR    = 2'd3
  } action_t;

  localparam logic REG_FWD_COUNT = 1'b0;
  localparam logic REG_FBK_COUNT = 1'b1;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic clr;  // zero the accumulator
    logic vld;  // a read was issued this cycle
    logic neg;  // feedback term, subtract
  } mac_ctl_t;

endpackage

`default_nettype wire

/* rtl/iirq15_ram.sv */
// Simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module iirq15_ram #(
  parameter int ADDR_W = 6,
  parameter int DATA_W = 16
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [0:(1 << ADDR_W)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/iirq15_mac.sv */
// Pipelined multiply-accumulate: registered product, then 48-bit add or subtract.
`default_nettype none

module iirq15_mac
  import iirq15_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire mac_ctl_t                   ctl,
  input  wire logic signed [SAMPLE_W-1:0] hist_q,
  input  wire logic signed [SAMPLE_W-1:0] coef_q,
  output logic signed      [ACC_W-1:0]    acc,
  output logic                            busy
);

  logic                     vld_d1, vld_d2;
  logic                     neg_d1, neg_d2;
  logic signed [PROD_W-1:0] prod;

  // valid and sign are delayed to line up with the registered read data and product
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_d1 <= 1'b0;
      vld_d2 <= 1'b0;
    end else begin
      vld_d1 <= ctl.vld;
      vld_d2 <= vld_d1;
    end
  end

  always_ff @(posedge clk) begin
    neg_d1 <= ctl.neg;
    neg_d2 <= neg_d1;
    prod   <= hist_q * coef_q;
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc <= '0;
    end else if (vld_d2) begin
      if (neg_d2) begin
        acc <= acc - ACC_W'(prod);
      end else begin
        acc <= acc + ACC_W'(prod);
      end
    end
  end

  assign busy = vld_d1 | vld_d2;

endmodule

`default_nettype wire

/* rtl/iir_filter_q15_direct_form_one.sv */
// Q15 direct form I IIR filter: sequencer, history and coefficient memories, MAC.
// Filter transaction: the single MAC walks the M forward and K feedback taps, M and K as
// clamped, one tap per cycle through the memory read ports; the result is registered after
// the drain, and the next transaction is taken once it is, unless an earlier result is stalled.
// Load transactions are written on acceptance; a history clear sweeps every history address.
// After reset a sweep over the same addresses zeroes histories and coefficients; no
// transaction is accepted meanwhile. Configuration writes are taken at any time.
`default_nettype none

module iir_filter_q15_direct_form_one
  import iirq15_pkg::*;
#(
  parameter int MAX_TAPS = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_write,
  input  wire logic                       cfg_index,
  input  wire logic        [CFG_W-1:0]    cfg_data,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic        [1:0]          action,
  input  wire logic        [TAP_IDX_W-1:0] tap_index,
  input  wire logic signed [SAMPLE_W-1:0] value,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed      [SAMPLE_W-1:0] filtered_sample,
  output logic                            saturated
);

  localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CW = AW + 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_TAPS - 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_FWD   = 5'b00100,
    S_BACK  = 5'b01000,
    S_DRAIN = 5'b10000
  } state_t;

  state_t                state;
  logic [FWD_CNT_W-1:0]  fwd_count;
  logic [FBK_CNT_W-1:0]  fbk_count;
  logic [AW-1:0]         ptr, ha, j;
  logic [CW-1:0]         m_cnt;
  logic [AW-1:0]         k_cnt;
  logic [AW:0]           clr_idx;
  logic                  clr_coef;

  logic                  in_acc;
  action_t               act;
  logic [AW-1:0]         ptr_inc, ptr_dec, ha_dec;
  logic [CW-1:0]         m_lim;
  logic [AW-1:0]         k_lim;
  logic                  drain_done;

  logic                  hist_we, coef_we;
  logic [AW:0]           hist_waddr, coef_waddr, hist_raddr, coef_raddr;
  logic [SAMPLE_W-1:0]   hist_wdata, coef_wdata, hist_rdata, coef_rdata;

  mac_ctl_t              mac_ctl;
  logic signed [ACC_W-1:0] mac_acc;
  logic                  mac_busy;
  logic signed [ACC_W-1:0] acc_sh;
  logic signed [SAMPLE_W-1:0] y;
  logic                  y_sat;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign act      = action_t'(action);

  assign ptr_inc = (ptr == LAST_SLOT) ? '0 : ptr + AW'(1);
  assign ptr_dec = (ptr == '0) ? LAST_SLOT : ptr - AW'(1);
  assign ha_dec  = (ha == '0) ? LAST_SLOT : ha - AW'(1);

  assign m_lim = (32'(fwd_count) > 32'(MAX_TAPS)) ? CW'(MAX_TAPS) : CW'(fwd_count);
  assign k_lim = (32'(fbk_count) > 32'(MAX_TAPS - 1)) ? LAST_SLOT : AW'(fbk_count);

  // floor shift, then clip to 16 bits
  assign acc_sh = mac_acc >>> Q_SHIFT;
  always_comb begin
    y_sat = 1'b0;
    y     = acc_sh[SAMPLE_W-1:0];
    if (acc_sh > ACC_W'(32767)) begin
      y     = 16'sh7fff;
      y_sat = 1'b1;
    end else if (acc_sh < -ACC_W'(32768)) begin
      y     = 16'sh8000;
      y_sat = 1'b1;
    end
  end

  assign drain_done = (state == S_DRAIN) && !mac_busy && (!out_valid || !out_stall);

  // memory ports
  always_comb begin
    hist_we    = 1'b0;
    hist_waddr = {1'b0, ptr_inc};
    hist_wdata = value;
    coef_we    = 1'b0;
    coef_waddr = {1'b0, AW'(tap_index)};
    coef_wdata = value;
    case (state)
      S_CLEAR: begin
        hist_we    = 1'b1;
        hist_waddr = clr_idx;
        hist_wdata = '0;
        coef_we    = clr_coef;
        coef_waddr = clr_idx;
        coef_wdata = '0;
      end
      S_IDLE: begin
        if (in_acc) begin
          case (act)
            ACT_FILTER: begin
              hist_we = 1'b1;
            end
            ACT_LOAD_FWD: begin
              coef_we    = (32'(tap_index) < 32'(MAX_TAPS));
              coef_waddr = {1'b0, AW'(tap_index)};
            end
            ACT_LOAD_FBK: begin
              coef_we    = (tap_index != '0) && (32'(tap_index) < 32'(MAX_TAPS));
              coef_waddr = {1'b1, AW'(tap_index)};
            end
            default: begin
            end
          endcase
        end
      end
      S_DRAIN: begin
        hist_we    = drain_done;
        hist_waddr = {1'b1, ptr};
        hist_wdata = y;
      end
      default: begin
      end
    endcase
  end

  // x and y histories share one pointer: x[n-j] at {0,p-j}, y[n-j] at {1,p-j}
  assign hist_raddr = {(state == S_BACK), ha};
  assign coef_raddr = {(state == S_BACK), j};

  assign mac_ctl.clr = in_acc && (act == ACT_FILTER);
  assign mac_ctl.vld = (state == S_FWD) || (state == S_BACK);
  assign mac_ctl.neg = (state == S_BACK);

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_count <= FWD_CNT_W'(1);
      fbk_count <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FWD_COUNT: fwd_count <= cfg_data[FWD_CNT_W-1:0];
        REG_FBK_COUNT: fbk_count <= cfg_data[FBK_CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_idx  <= '0;
      clr_coef <= 1'b1;
      ptr      <= '0;
      ha       <= '0;
      j        <= '0;
      m_cnt    <= '0;
      k_cnt    <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + CW'(1);
          if (clr_idx == '1) begin
            state    <= S_IDLE;
            clr_coef <= 1'b0;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            case (act)
              ACT_FILTER: begin
                ptr   <= ptr_inc;
                m_cnt <= m_lim;
                k_cnt <= k_lim;
                if (m_lim != '0) begin
                  state <= S_FWD;
                  j     <= '0;
                  ha    <= ptr_inc;
                end else if (k_lim != '0) begin
                  state <= S_BACK;
                  j     <= AW'(1);
                  ha    <= ptr;
                end else begin
                  state <= S_DRAIN;
                end
              end
              ACT_CLEAR: begin
                state   <= S_CLEAR;
                clr_idx <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_FWD: begin
          j  <= j + AW'(1);
          ha <= ha_dec;
          if (CW'(j) == m_cnt - CW'(1)) begin
            if (k_cnt != '0) begin
              state <= S_BACK;
              j     <= AW'(1);
              ha    <= ptr_dec;
            end else begin
              state <= S_DRAIN;
            end
          end
        end
        S_BACK: begin
          j  <= j + AW'(1);
          ha <= ha_dec;
          if (j == k_cnt) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (drain_done) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (drain_done) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain_done) begin
      filtered_sample <= y;
      saturated       <= y_sat;
    end
  end

  iirq15_ram #(
    .ADDR_W(CW),
    .DATA_W(SAMPLE_W)
  ) u_hist (
    .clk  (clk),
    .we   (hist_we),
    .waddr(hist_waddr),
    .wdata(hist_wdata),
    .raddr(hist_raddr),
    .rdata(hist_rdata)
  );

  iirq15_ram #(
    .ADDR_W(CW),
    .DATA_W(SAMPLE_W)
  ) u_coef (
    .clk  (clk),
    .we   (coef_we),
    .waddr(coef_waddr),
    .wdata(coef_wdata),
    .raddr(coef_raddr),
    .rdata(coef_rdata)
  );

  iirq15_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .ctl   (mac_ctl),
    .hist_q(hist_rdata),
    .coef_q(coef_rdata),
    .acc   (mac_acc),
    .busy  (mac_busy)
  );

`ifndef SYNTHESIS
  // history must not change while the taps are being walked
  a_no_hist_write_in_walk: assert property (@(posedge clk) disable iff (rst)
    (state == S_FWD || state == S_BACK) |-> !hist_we)
    else $error("history written during tap walk");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |->
      (filtered_sample == 16'sh7fff || filtered_sample == 16'sh8000))
    else $error("saturation flag without clipped value");

  a_acc_cleared: assert property (@(posedge clk) disable iff (rst)
    (in_acc && act == ACT_FILTER) |=> (mac_acc == '0))
    else $error("accumulator not cleared at sample start");

  a_fwd_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_FWD) |-> (CW'(j) < m_cnt))
    else $error("forward tap index beyond tap count");

  a_result_after_drain: assert property (@(posedge clk) disable iff (rst)
    (!out_valid ##1 out_valid) |-> $past(state) == S_DRAIN)
    else $error("result raised outside drain");
`endif

endmodule

`default_nettype wire

/* sim/iir_filter_q15_direct_form_one_tb.sv */
// Self-checking testbench for the Q15 direct form I IIR filter with a scoreboard class.
`timescale 1ns / 1ps

module iir_filter_q15_direct_form_one_tb;
  import iirq15_pkg::*;

  localparam int TAP_DEPTH      = 32;
  localparam int SETTLE_CYCLES  = 2 * TAP_DEPTH + 16;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_OFF_LEN   = 400;
  localparam int PHASE_ITEMS    = 157;
  localparam int PHASE_COUNT    = 12;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] y;
    logic                       sat;
  } filter_result_t;

  class iir_scoreboard;
    int unsigned fwd_count;
    int unsigned fbk_count;
    logic signed [SAMPLE_W-1:0] x_hist [TAP_DEPTH];
    logic signed [SAMPLE_W-1:0] y_hist [TAP_DEPTH];
    logic signed [SAMPLE_W-1:0] b_coef [TAP_DEPTH];
    logic signed [SAMPLE_W-1:0] a_coef [TAP_DEPTH];
    filter_result_t expected_q [$];
    int errors;

    function new();
      fwd_count = 1;
      fbk_count = 0;
      errors    = 0;
      clear_history();
      foreach (b_coef[i]) begin
        b_coef[i] = '0;
        a_coef[i] = '0;
      end
    endfunction

    function void clear_history();
      foreach (x_hist[i]) begin
        x_hist[i] = '0;
        y_hist[i] = '0;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_reg(logic idx, logic [CFG_W-1:0] data);
      if (idx == REG_FWD_COUNT) fwd_count = 32'(data);
      else fbk_count = 32'(data[FBK_CNT_W-1:0]);
    endfunction

    // Accepted input transaction: update state, queue the output of a filter step.
    function void note_item(action_t act, logic [TAP_IDX_W-1:0] idx,
                            logic signed [SAMPLE_W-1:0] v);
      int m;
      int k;
      logic signed [ACC_W-1:0] acc;
      logic signed [ACC_W-1:0] shifted;
      filter_result_t res;
      case (act)
        ACT_LOAD_FWD: begin
          b_coef[idx] = v;
        end
        ACT_LOAD_FBK: begin
          if (idx != 0) a_coef[idx] = v;
        end
        ACT_CLEAR: begin
          clear_history();
        end
        default: begin
          m = (fwd_count > TAP_DEPTH) ? TAP_DEPTH : int'(fwd_count);
          k = (fbk_count > TAP_DEPTH - 1) ? TAP_DEPTH - 1 : int'(fbk_count);
          for (int j = TAP_DEPTH - 1; j > 0; j--) x_hist[j] = x_hist[j-1];
          x_hist[0] = v;
          acc = '0;
          for (int j = 0; j < m; j++) acc += x_hist[j] * b_coef[j];
          for (int j = 1; j <= k; j++) acc -= y_hist[j-1] * a_coef[j];
          shifted = acc >>> Q_SHIFT;
          res.sat = 1'b1;
          if (shifted > 32767) res.y = 16'sh7FFF;
          else if (shifted < -32768) res.y = 16'sh8000;
          else begin
            res.y   = shifted[SAMPLE_W-1:0];
            res.sat = 1'b0;
          end
          for (int j = TAP_DEPTH - 1; j > 0; j--) y_hist[j] = y_hist[j-1];
          y_hist[0] = res.y;
          expected_q.push_back(res);
        end
      endcase
    endfunction

    function void check_result(logic signed [SAMPLE_W-1:0] got_y, logic got_sat);
      filter_result_t exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        $error("filtered_sample %0d arrived with no sample pending", $signed(got_y));
        return;
      end
      exp_r = expected_q.pop_front();
      if (got_y !== exp_r.y) begin
        errors++;
        $error("filtered_sample: expected %0d, got %0d", $signed(exp_r.y), $signed(got_y));
      end
      if (got_sat !== exp_r.sat) begin
        errors++;
        $error("saturated: expected %0b, got %0b", exp_r.sat, got_sat);
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       cfg_write;
  logic                       cfg_index;
  logic [CFG_W-1:0]           cfg_data;
  logic                       in_valid;
  logic                       in_stall;
  logic [1:0]                 action;
  logic [TAP_IDX_W-1:0]       tap_index;
  logic signed [SAMPLE_W-1:0] value;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [SAMPLE_W-1:0] filtered_sample;
  logic                       saturated;

  iir_scoreboard sb;
  bit send_gappy = 1'b1;
  bit recv_gappy = 1'b1;
  int hold_off_cycles = 0;
  int idle_cycles = 0;

  iir_filter_q15_direct_form_one #(
    .MAX_TAPS(TAP_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .tap_index(tap_index),
    .value(value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .filtered_sample(filtered_sample),
    .saturated(saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_gap(bit gappy);
    if (!gappy || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      default: return 16'($urandom);
    endcase
  endfunction

  // Small coefficients keep long filters out of saturation most of the time.
  function automatic logic signed [SAMPLE_W-1:0] pick_coef(bit small_coefs);
    if (small_coefs) return 16'($urandom_range(0, 4095) - 2048);
    return pick_sample();
  endfunction

  task automatic send_item(input action_t act, input logic [TAP_IDX_W-1:0] idx,
                           input logic signed [SAMPLE_W-1:0] v);
    int gap;
    gap = draw_gap(send_gappy);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    tap_index <= idx;
    value     <= v;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_counts(input logic [CFG_W-1:0] m_data, input logic [CFG_W-1:0] k_data);
    cfg_write <= 1'b1;
    cfg_index <= REG_FWD_COUNT;
    cfg_data  <= m_data;
    @(posedge clk);
    cfg_index <= REG_FBK_COUNT;
    cfg_data  <= k_data;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Clears can still be sweeping after the last output, hence the settle time.
  // Dropping in_valid and waiting for the clock first lets the scoreboard see the last accepted transaction.
  task automatic drain_and_settle;
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] m_data, input logic [CFG_W-1:0] k_data,
                           input bit small_coefs, input bit hold_off);
    int m;
    int k;
    int r;
    drain_and_settle();
    write_counts(m_data, k_data);
    m = (m_data > TAP_DEPTH) ? TAP_DEPTH : int'(m_data);
    k = int'(k_data[FBK_CNT_W-1:0]);
    for (int j = 0; j < m; j++) send_item(ACT_LOAD_FWD, 5'(j), pick_coef(small_coefs));
    for (int j = 1; j <= k; j++) send_item(ACT_LOAD_FBK, 5'(j), pick_coef(small_coefs));
    send_item(ACT_CLEAR, 5'($urandom), 16'($urandom));
    if (hold_off) hold_off_cycles = HOLD_OFF_LEN;
    for (int j = m + k + 1; j < PHASE_ITEMS; j++) begin
      r = $urandom_range(0, 99);
      if (r < 80) send_item(ACT_FILTER, 5'($urandom), pick_sample());
      else if (r < 88) send_item(ACT_LOAD_FWD, 5'($urandom), pick_coef(small_coefs));
      else if (r < 96) send_item(ACT_LOAD_FBK, 5'($urandom), pick_coef(small_coefs));
      else send_item(ACT_CLEAR, 5'($urandom), 16'($urandom));
    end
  endtask

  // Result side: random stall per transaction, plus one long hold-off on request.
  initial begin : result_sink
    int stall_cycles;
    out_stall <= 1'b1;
    do @(posedge clk); while (rst);
    forever begin
      stall_cycles = draw_gap(recv_gappy);
      if (hold_off_cycles > 0) begin
        stall_cycles += hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (stall_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (stall_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_write) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_item(action_t'(action), tap_index, value);
      if (out_valid && !out_stall) sb.check_result(filtered_sample, saturated);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[iir_filter_q15_direct_form_one] ERROR");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    rst       <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= REG_FWD_COUNT;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    action    <= ACT_FILTER;
    tap_index <= '0;
    value     <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: extreme values and indexes, ignored feedback tap zero, clear keeps taps.
    write_counts(6'd2, 6'd1);
    send_item(ACT_LOAD_FWD, 5'd0, 16'sh7FFF);
    send_item(ACT_LOAD_FWD, 5'd31, 16'sh8000);
    send_item(ACT_LOAD_FWD, 5'd1, 16'sh8000);
    send_item(ACT_LOAD_FBK, 5'd0, 16'sh3039);
    send_item(ACT_LOAD_FBK, 5'd1, 16'sh8000);
    send_item(ACT_LOAD_FBK, 5'd31, 16'sh7FFF);
    send_item(ACT_FILTER, 5'd0, 16'sh7FFF);
    send_item(ACT_FILTER, 5'd31, 16'sh8000);
    send_item(ACT_FILTER, 5'd0, 16'sh0000);
    send_item(ACT_FILTER, 5'd0, 16'sh7FFF);
    send_item(ACT_FILTER, 5'd0, 16'sh8000);
    send_item(ACT_CLEAR, 5'd31, 16'shFFFF);
    send_item(ACT_FILTER, 5'd0, 16'sh0000);
    send_item(ACT_FILTER, 5'd0, 16'sh0001);
    send_item(ACT_FILTER, 5'd0, 16'shFFFF);
    send_item(ACT_LOAD_FWD, 5'd0, 16'sh0001);
    send_item(ACT_LOAD_FWD, 5'd1, 16'sh0000);
    send_item(ACT_LOAD_FBK, 5'd1, 16'sh0000);
    send_item(ACT_FILTER, 5'd0, 16'shFFFF);
    send_item(ACT_FILTER, 5'd0, 16'sh8000);
    send_item(ACT_FILTER, 5'd0, 16'sh7FFF);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      send_gappy = ($urandom_range(0, 3) != 0);
      recv_gappy = ($urandom_range(0, 3) != 0);
      case (p)
        0: run_phase(6'd0, 6'd0, 1'b1, 1'b0);
        1: begin
          send_gappy = 1'b0;
          recv_gappy = 1'b0;
          run_phase(6'h3F, 6'h3F, 1'b1, 1'b0);
        end
        2: begin
          send_gappy = 1'b1;
          recv_gappy = 1'b1;
          run_phase(6'd32, 6'h1F, 1'b0, 1'b0);
        end
        3: run_phase(6'd1, 6'd0, 1'b0, 1'b0);
        default: run_phase(6'($urandom), 6'($urandom), $urandom_range(0, 3) != 0, p == 5);
      endcase
    end

    drain_and_settle();
    if (sb.errors == 0) $display("[iir_filter_q15_direct_form_one] OK");
    else $display("[iir_filter_q15_direct_form_one] ERROR");
    $finish;
  end

endmodule
